FILE: hw/rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, rounding constants and sideband types shared by the ray/sphere
// intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CB         = 32;
  localparam int UNIT_FRAC  = 30;
  localparam int NORM_GUARD = 15;

  localparam int SQ_W    = 2 * CB;
  localparam int LG_IN_W = SQ_W + 2 * NORM_GUARD;
  localparam int LG_W    = LG_IN_W / 2;
  localparam int QT_W    = UNIT_FRAC + 1;
  localparam int NUM_W   = CB + UNIT_FRAC + NORM_GUARD;
  localparam int PR_W    = 2 * CB + 1;
  localparam int DOT_W   = PR_W + 2;
  localparam int H_W     = DOT_W - UNIT_FRAC;
  localparam int Q_W     = 72;
  localparam int S_W     = Q_W / 2;
  localparam int T_W     = 39;
  localparam int TP_W    = T_W + CB;
  localparam int R_W     = TP_W - UNIT_FRAC;
  localparam int PS_W    = R_W + 1;

  localparam logic signed [DOT_W-1:0] DOT_HALF = DOT_W'(1) << (UNIT_FRAC - 1);
  localparam logic signed [TP_W-1:0]  TP_HALF  = TP_W'(1) << (UNIT_FRAC - 1);

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE  = 2'd1;
  localparam logic [1:0] HIT_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0][CB-1:0] hd;
    logic [2:0][CB:0]   m;
    logic [2:0][CB-1:0] p;
    logic [CB-2:0]      rad;
    logic               zero;
  } side1_t;

  typedef struct packed {
    logic [2:0][CB-1:0] u;
    logic [2:0][CB-1:0] p;
    logic [H_W-1:0]     h;
    logic               neg;
    logic               zer;
  } side2_t;

  function automatic logic [CB-1:0] sat_coord(input logic signed [PS_W-1:0] v);
    if (v > $signed({{(PS_W-CB+1){1'b0}}, {(CB-1){1'b1}}})) begin
      sat_coord = {1'b0, {(CB-1){1'b1}}};
    end else if (v < $signed({{(PS_W-CB+1){1'b1}}, {(CB-1){1'b0}}})) begin
      sat_coord = {1'b1, {(CB-1){1'b0}}};
    end else begin
      sat_coord = v[CB-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Fixed-point ray/sphere intersection: normalizes the heading, solves the
// quadratic and returns up to two saturated hit points.
//
//   channel   handshake         payload
//   ------    ---------------   --------------------------------------------
//   command   start / busy      center_*, sphere_radius, start_*, heading_*
//   result    done              hit_count, far_*, near_*
//
// One transaction enters per cycle; busy is always low.
// The path runs through the two bit-serial square root pipelines
// (47 and 36 stages) and the 31-stage divider for the unit vector.
// rst (synchronous) clears all stage valid bits; data registers are not reset.
// done marks a result for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [rsi_pkg::CB-1:0] center_x,
  input  logic signed [rsi_pkg::CB-1:0] center_y,
  input  logic signed [rsi_pkg::CB-1:0] center_z,
  input  logic [rsi_pkg::CB-2:0]        sphere_radius,
  input  logic signed [rsi_pkg::CB-1:0] start_x,
  input  logic signed [rsi_pkg::CB-1:0] start_y,
  input  logic signed [rsi_pkg::CB-1:0] start_z,
  input  logic signed [rsi_pkg::CB-1:0] heading_x,
  input  logic signed [rsi_pkg::CB-1:0] heading_y,
  input  logic signed [rsi_pkg::CB-1:0] heading_z,
  output logic                          done,
  output logic [1:0]                    hit_count,
  output logic signed [rsi_pkg::CB-1:0] far_x,
  output logic signed [rsi_pkg::CB-1:0] far_y,
  output logic signed [rsi_pkg::CB-1:0] far_z,
  output logic signed [rsi_pkg::CB-1:0] near_x,
  output logic signed [rsi_pkg::CB-1:0] near_y,
  output logic signed [rsi_pkg::CB-1:0] near_z
);

  import rsi_pkg::*;

  // input decode
  logic signed [CB-1:0]   in_o   [3];
  logic signed [CB-1:0]   in_p   [3];
  logic signed [CB-1:0]   in_hd  [3];
  logic signed [CB:0]     in_m   [3];
  logic signed [SQ_W-1:0] in_hsq [3];

  assign busy = 1'b0;

  assign in_o[0]  = center_x;
  assign in_o[1]  = center_y;
  assign in_o[2]  = center_z;
  assign in_p[0]  = start_x;
  assign in_p[1]  = start_y;
  assign in_p[2]  = start_z;
  assign in_hd[0] = heading_x;
  assign in_hd[1] = heading_y;
  assign in_hd[2] = heading_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_m[i]   = in_p[i] - in_o[i];
      in_hsq[i] = in_hd[i] * in_hd[i];
    end
  end

  // stage: squares of heading
  logic            p1_vld;
  logic [SQ_W-2:0] p1_sqr [3];
  side1_t          p1_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      p1_sqr[i]   <= in_hsq[i][SQ_W-2:0];
      p1_sd.hd[i] <= in_hd[i];
      p1_sd.m[i]  <= in_m[i];
      p1_sd.p[i]  <= in_p[i];
    end
    p1_sd.rad  <= sphere_radius;
    p1_sd.zero <= 1'b0;
  end

  // stage: squared length
  logic            p2_vld;
  logic [SQ_W-1:0] p2_sq;
  logic [SQ_W-1:0] sq_sum;
  side1_t          p1_sdz;
  side1_t          p2_sd;

  assign sq_sum = {1'b0, p1_sqr[0]} + {1'b0, p1_sqr[1]} + {1'b0, p1_sqr[2]};

  always_comb begin
    p1_sdz      = p1_sd;
    p1_sdz.zero = (sq_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    p2_sq <= sq_sum;
    p2_sd <= p1_sdz;
  end

  // length root
  logic            s1_vld;
  logic [LG_W-1:0] s1_lg;
  side1_t          s1_sd;

  rsi_isqrt #(
    .IN_W   (LG_IN_W),
    .SIDE_W ($bits(side1_t))
  ) u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (p2_vld),
    .in_val   ({p2_sq, {(2*NORM_GUARD){1'b0}}}),
    .in_side  (p2_sd),
    .out_vld  (s1_vld),
    .out_root (s1_lg),
    .out_side (s1_sd)
  );

  // divider for the unit vector, three lanes
  logic [CB-1:0]    dv_mag [3];
  logic [NUM_W-1:0] dv_num [3];

  logic                     dv_vld [QT_W+1];
  logic [LG_W-1:0]          dv_d   [QT_W+1];
  logic [2:0][LG_W-1:0]     dv_rm  [QT_W+1];
  logic [2:0][QT_W-1:0]     dv_n   [QT_W+1];
  logic [2:0][QT_W-1:0]     dv_q   [QT_W+1];
  side1_t                   dv_sd  [QT_W+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_mag[i] = s1_sd.hd[i][CB-1] ? (~s1_sd.hd[i] + 1'b1) : s1_sd.hd[i];
      dv_num[i] = {dv_mag[i], {(UNIT_FRAC+NORM_GUARD){1'b0}}}
                + {{(NUM_W-LG_W+1){1'b0}}, s1_lg[LG_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= s1_vld;
    end
    dv_d[0]  <= s1_lg;
    dv_sd[0] <= s1_sd;
    for (int i = 0; i < 3; i++) begin
      dv_rm[0][i] <= {1'b0, dv_num[i][NUM_W-1:QT_W]};
      dv_n[0][i]  <= dv_num[i][QT_W-1:0];
      dv_q[0][i]  <= '0;
    end
  end

  for (genvar j = 0; j < QT_W; j++) begin : g_div
    logic [LG_W:0] cand [3];
    logic [LG_W:0] diff [3];
    logic [2:0]    ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = {dv_rm[j][i], dv_n[j][i][QT_W-1]};
        diff[i] = cand[i] - {1'b0, dv_d[j]};
        ge[i]   = cand[i] >= {1'b0, dv_d[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else begin
        dv_vld[j+1] <= dv_vld[j];
      end
      dv_d[j+1]  <= dv_d[j];
      dv_sd[j+1] <= dv_sd[j];
      for (int i = 0; i < 3; i++) begin
        dv_rm[j+1][i] <= ge[i] ? diff[i][LG_W-1:0] : cand[i][LG_W-1:0];
        dv_n[j+1][i]  <= {dv_n[j][i][QT_W-2:0], 1'b0};
        dv_q[j+1][i]  <= {dv_q[j][i][QT_W-2:0], ge[i]};
      end
    end
  end

  // stage: signed unit vector
  logic [CB-1:0]        u_mag [3];
  logic                 u_vld;
  logic signed [CB-1:0] u_u   [3];
  side1_t               u_sd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_mag[i] = {1'b0, dv_q[QT_W][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_vld <= 1'b0;
    end else begin
      u_vld <= dv_vld[QT_W];
    end
    u_sd <= dv_sd[QT_W];
    for (int i = 0; i < 3; i++) begin
      if (dv_sd[QT_W].zero) begin
        u_u[i] <= '0;
      end else if (dv_sd[QT_W].hd[i][CB-1]) begin
        u_u[i] <= -u_mag[i];
      end else begin
        u_u[i] <= u_mag[i];
      end
    end
  end

  // stage: u * m
  logic signed [PR_W-1:0] um    [3];
  logic                   m1_vld;
  logic signed [PR_W-1:0] m1_um [3];
  logic signed [CB-1:0]   m1_u  [3];
  side1_t                 m1_sd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      um[i] = u_u[i] * $signed(u_sd.m[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= u_vld;
    end
    m1_sd <= u_sd;
    for (int i = 0; i < 3; i++) begin
      m1_um[i] <= um[i];
      m1_u[i]  <= u_u[i];
    end
  end

  // stage: h, rounded
  logic signed [DOT_W-1:0] dsum;
  logic                    h_vld;
  logic signed [H_W-1:0]   h_h;
  logic signed [CB-1:0]    h_u [3];
  side1_t                  h_sd;

  assign dsum = m1_um[0] + m1_um[1] + m1_um[2] + DOT_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= m1_vld;
    end
    h_h  <= dsum[DOT_W-1:UNIT_FRAC];
    h_sd <= m1_sd;
    for (int i = 0; i < 3; i++) begin
      h_u[i] <= m1_u[i];
    end
  end

  // stage: squares for the discriminant
  logic signed [2*H_W-1:0] hh;
  logic signed [2*CB+1:0]  mm [3];
  logic [2*CB-3:0]         rr;
  logic                    q1_vld;
  logic signed [Q_W-1:0]   q1_hh;
  logic signed [2*CB+1:0]  q1_mm [3];
  logic [2*CB-3:0]         q1_rr;
  logic [CB-1:0]           q1_u [3];
  logic [CB-1:0]           q1_p [3];
  logic [H_W-1:0]          q1_h;

  assign hh = h_h * h_h;
  assign rr = h_sd.rad * h_sd.rad;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mm[i] = $signed(h_sd.m[i]) * $signed(h_sd.m[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
    end else begin
      q1_vld <= h_vld;
    end
    q1_hh <= hh[Q_W-1:0];
    q1_rr <= rr;
    q1_h  <= h_h;
    for (int i = 0; i < 3; i++) begin
      q1_mm[i] <= mm[i];
      q1_u[i]  <= h_u[i];
      q1_p[i]  <= h_sd.p[i];
    end
  end

  // stage: discriminant
  logic signed [Q_W-1:0] qsum;
  logic                  q2_vld;
  logic [Q_W-1:0]        q2_q;
  side2_t                q2_sd;
  side2_t                s2_in;

  assign qsum = q1_hh + $signed({{(Q_W-2*CB+2){1'b0}}, q1_rr})
              - q1_mm[0] - q1_mm[1] - q1_mm[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_vld <= 1'b0;
    end else begin
      q2_vld <= q1_vld;
    end
    q2_q      <= qsum;
    q2_sd.h   <= q1_h;
    q2_sd.neg <= 1'b0;
    q2_sd.zer <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      q2_sd.u[i] <= q1_u[i];
      q2_sd.p[i] <= q1_p[i];
    end
  end

  always_comb begin
    s2_in     = q2_sd;
    s2_in.neg = q2_q[Q_W-1];
    s2_in.zer = (q2_q == '0);
  end

  // discriminant root
  logic           s2_vld;
  logic [S_W-1:0] s2_s;
  side2_t         s2_sd;

  rsi_isqrt #(
    .IN_W   (Q_W),
    .SIDE_W ($bits(side2_t))
  ) u_disc_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (q2_vld),
    .in_val   (q2_q),
    .in_side  (s2_in),
    .out_vld  (s2_vld),
    .out_root (s2_s),
    .out_side (s2_sd)
  );

  // stage: roots t
  logic signed [T_W-1:0] s_ext;
  logic signed [T_W-1:0] h_ext;
  logic                  t_vld;
  logic signed [T_W-1:0] t_far;
  logic signed [T_W-1:0] t_near;
  logic signed [CB-1:0]  t_u [3];
  logic [CB-1:0]         t_p [3];
  logic [1:0]            t_cnt;

  assign s_ext = $signed({{(T_W-S_W){1'b0}}, s2_s});
  assign h_ext = $signed(s2_sd.h);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else begin
      t_vld <= s2_vld;
    end
    t_far  <= s_ext - h_ext;
    t_near <= -h_ext - s_ext;
    if (s2_sd.neg) begin
      t_cnt <= HIT_NONE;
    end else if (s2_sd.zer) begin
      t_cnt <= HIT_ONE;
    end else begin
      t_cnt <= HIT_TWO;
    end
    for (int i = 0; i < 3; i++) begin
      t_u[i] <= s2_sd.u[i];
      t_p[i] <= s2_sd.p[i];
    end
  end

  // stage: t * u
  logic signed [TP_W-1:0] tpf [3];
  logic signed [TP_W-1:0] tpn [3];
  logic                   tu_vld;
  logic signed [TP_W-1:0] tu_far  [3];
  logic signed [TP_W-1:0] tu_near [3];
  logic [CB-1:0]          tu_p [3];
  logic [1:0]             tu_cnt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tpf[i] = t_far * t_u[i];
      tpn[i] = t_near * t_u[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tu_vld <= 1'b0;
    end else begin
      tu_vld <= t_vld;
    end
    tu_cnt <= t_cnt;
    for (int i = 0; i < 3; i++) begin
      tu_far[i]  <= tpf[i];
      tu_near[i] <= tpn[i];
      tu_p[i]    <= t_p[i];
    end
  end

  // stage: round offsets
  logic signed [TP_W-1:0] rf [3];
  logic signed [TP_W-1:0] rn [3];
  logic                   r1_vld;
  logic signed [R_W-1:0]  r1_far  [3];
  logic signed [R_W-1:0]  r1_near [3];
  logic signed [CB-1:0]   r1_p [3];
  logic [1:0]             r1_cnt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rf[i] = tu_far[i] + TP_HALF;
      rn[i] = tu_near[i] + TP_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else begin
      r1_vld <= tu_vld;
    end
    r1_cnt <= tu_cnt;
    for (int i = 0; i < 3; i++) begin
      r1_far[i]  <= rf[i][TP_W-1:UNIT_FRAC];
      r1_near[i] <= rn[i][TP_W-1:UNIT_FRAC];
      r1_p[i]    <= tu_p[i];
    end
  end

  // output: add start point, saturate, blank unused slots
  logic signed [PS_W-1:0] pf [3];
  logic signed [PS_W-1:0] pn [3];
  logic [CB-1:0]          o_far  [3];
  logic [CB-1:0]          o_near [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pf[i]     = r1_p[i] + r1_far[i];
      pn[i]     = r1_p[i] + r1_near[i];
      o_far[i]  = (r1_cnt != HIT_NONE) ? sat_coord(pf[i]) : '0;
      o_near[i] = (r1_cnt == HIT_TWO) ? sat_coord(pn[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r1_vld;
    end
    hit_count <= r1_cnt;
    far_x     <= o_far[0];
    far_y     <= o_far[1];
    far_z     <= o_far[2];
    near_x    <= o_near[0];
    near_y    <= o_near[1];
    near_z    <= o_near[2];
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit_count == HIT_NONE || hit_count == HIT_ONE || hit_count == HIT_TWO))
    else $error("hit_count out of range");

  a_miss_blank: assert property (@(posedge clk) disable iff (rst)
    (done && hit_count == HIT_NONE) |-> (far_x == '0 && far_y == '0 && far_z == '0))
    else $error("far slot not blank on a miss");

  a_near_blank: assert property (@(posedge clk) disable iff (rst)
    (done && hit_count != HIT_TWO) |-> (near_x == '0 && near_y == '0 && near_z == '0))
    else $error("near slot not blank without two hits");

endmodule

FILE: hw/rtl/rsi_isqrt.sv
// ----------------------------------------------------------------------------
// rsi_isqrt
// Pipelined floor square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module rsi_isqrt #(
  parameter int IN_W   = 94,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [IN_W-1:0]     in_val,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW = IN_W / 2;

  logic              vld [RW+1];
  logic [IN_W-1:0]   xs  [RW+1];
  logic [RW-1:0]     rt  [RW+1];
  logic [RW:0]       rm  [RW+1];
  logic [SIDE_W-1:0] sd  [RW+1];

  assign vld[0] = in_vld;
  assign xs[0]  = in_val;
  assign rt[0]  = '0;
  assign rm[0]  = '0;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] cand;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          take;

    assign cand  = {rm[k], xs[k][IN_W-1 -: 2]};
    assign trial = {1'b0, rt[k], 2'b01};
    assign diff  = cand - trial;
    assign take  = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      xs[k+1] <= {xs[k][IN_W-3:0], 2'b00};
      rt[k+1] <= {rt[k][RW-2:0], take};
      rm[k+1] <= take ? diff[RW:0] : cand[RW:0];
      sd[k+1] <= sd[k];
    end
  end

  assign out_vld  = vld[RW];
  assign out_root = rt[RW];
  assign out_side = sd[RW];

endmodule

FILE: dv/rsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// Watches the command and result channels of ray_sphere_intersect, computes
// the expected hit count and hit points for every accepted transaction and
// compares each result with the oldest pending expectation.
// ----------------------------------------------------------------------------
module rsi_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [rsi_pkg::CB-1:0] center_x,
  input  logic signed [rsi_pkg::CB-1:0] center_y,
  input  logic signed [rsi_pkg::CB-1:0] center_z,
  input  logic [rsi_pkg::CB-2:0]        sphere_radius,
  input  logic signed [rsi_pkg::CB-1:0] start_x,
  input  logic signed [rsi_pkg::CB-1:0] start_y,
  input  logic signed [rsi_pkg::CB-1:0] start_z,
  input  logic signed [rsi_pkg::CB-1:0] heading_x,
  input  logic signed [rsi_pkg::CB-1:0] heading_y,
  input  logic signed [rsi_pkg::CB-1:0] heading_z,
  input  logic                          done,
  input  logic [1:0]                    hit_count,
  input  logic signed [rsi_pkg::CB-1:0] far_x,
  input  logic signed [rsi_pkg::CB-1:0] far_y,
  input  logic signed [rsi_pkg::CB-1:0] far_z,
  input  logic signed [rsi_pkg::CB-1:0] near_x,
  input  logic signed [rsi_pkg::CB-1:0] near_y,
  input  logic signed [rsi_pkg::CB-1:0] near_z,
  output int                            fail_count,
  output int                            pending,
  output int                            hits_seen [3]
);
  import rsi_pkg::*;

  typedef struct {
    logic [1:0]   cnt;
    logic [CB-1:0] pt [6];
  } hit_set_t;

  hit_set_t hits_q [$];

  localparam int W = 160;

  function automatic logic signed [W-1:0] ufrac_round(input logic signed [W-1:0] v);
    ufrac_round = (v + (W'(1) <<< (UNIT_FRAC - 1))) >>> UNIT_FRAC;
  endfunction

  function automatic logic [CB-1:0] clamp_coord(input logic signed [W-1:0] v);
    logic signed [W-1:0] hi, lo;
    hi = (W'(1) <<< (CB - 1)) - 1;
    lo = -(W'(1) <<< (CB - 1));
    if (v > hi) clamp_coord = hi[CB-1:0];
    else if (v < lo) clamp_coord = lo[CB-1:0];
    else clamp_coord = v[CB-1:0];
  endfunction

  function automatic logic [W-1:0] floor_sqrt(input logic [W-1:0] x);
    logic [W-1:0] r, c;
    r = 0;
    for (int i = 75; i >= 0; i--) begin
      c = r | (W'(1) << i);
      if (c * c <= x) r = c;
    end
    floor_sqrt = r;
  endfunction

  function automatic hit_set_t predict_hits(
    input logic signed [CB-1:0] cx, cy, cz, input logic [CB-2:0] rad_in,
    input logic signed [CB-1:0] px, py, pz, dx, dy, dz);
    logic signed [W-1:0] o [3], p [3], d [3], u [3], m [3];
    logic signed [W-1:0] sq, dot, h, q, s, rad, t;
    logic [W-1:0] lg, num, mg;
    hit_set_t r;
    o[0] = cx; o[1] = cy; o[2] = cz;
    p[0] = px; p[1] = py; p[2] = pz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    rad = {1'b0, rad_in};
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = p[i] - o[i];
      sq += d[i] * d[i];
    end
    if (sq == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
    end else begin
      lg = floor_sqrt(sq << (2 * NORM_GUARD));
      for (int i = 0; i < 3; i++) begin
        mg = d[i] < 0 ? -d[i] : d[i];
        num = mg << (UNIT_FRAC + NORM_GUARD);
        mg = (num + (lg >> 1)) / lg;
        u[i] = d[i] < 0 ? -$signed(mg) : $signed(mg);
      end
    end
    dot = 0;
    for (int i = 0; i < 3; i++) dot += u[i] * m[i];
    h = ufrac_round(dot);
    q = h * h + rad * rad;
    for (int i = 0; i < 3; i++) q -= m[i] * m[i];
    r.cnt = HIT_NONE;
    for (int i = 0; i < 6; i++) r.pt[i] = '0;
    if (q == 0) begin
      r.cnt = HIT_ONE;
      for (int i = 0; i < 3; i++) r.pt[i] = clamp_coord(p[i] + ufrac_round(-h * u[i]));
    end else if (q > 0) begin
      r.cnt = HIT_TWO;
      s = floor_sqrt(q);
      for (int i = 0; i < 3; i++) begin
        t = -h + s;
        r.pt[i] = clamp_coord(p[i] + ufrac_round(t * u[i]));
        t = -h - s;
        r.pt[3+i] = clamp_coord(p[i] + ufrac_round(t * u[i]));
      end
    end
    predict_hits = r;
  endfunction

  task automatic compare(input string name, input logic [CB-1:0] exp_v,
                         input logic [CB-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = hits_q.size();

  always @(posedge clk) begin
    hit_set_t e;
    if (rst) begin
      fail_count = 0;
      hits_seen = '{0, 0, 0};
    end else begin
      if (done) begin
        if (hits_q.size() == 0) begin
          $error("result with no pending transaction");
          fail_count++;
        end else begin
          e = hits_q.pop_front();
          if (e.cnt <= 2) hits_seen[e.cnt]++;
          compare("hit_count", CB'(e.cnt), CB'(hit_count));
          compare("far_x", e.pt[0], far_x);
          compare("far_y", e.pt[1], far_y);
          compare("far_z", e.pt[2], far_z);
          compare("near_x", e.pt[3], near_x);
          compare("near_y", e.pt[4], near_y);
          compare("near_z", e.pt[5], near_z);
        end
      end
      if (start && !busy)
        hits_q.push_back(predict_hits(center_x, center_y, center_z, sphere_radius,
                                      start_x, start_y, start_z,
                                      heading_x, heading_y, heading_z));
    end
  end
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random queries into ray_sphere_intersect, most random
// ones with random gaps; verdict from checker failures and pending count.
// ----------------------------------------------------------------------------
module tb;
  import rsi_pkg::*;

  localparam int LATENCY   = 126;
  localparam int MAX_CYCLE = 200000;

  logic clk, rst, start, busy, done;
  logic signed [CB-1:0] center_x, center_y, center_z, start_x, start_y, start_z;
  logic signed [CB-1:0] heading_x, heading_y, heading_z;
  logic [CB-2:0] sphere_radius;
  logic [1:0] hit_count;
  logic signed [CB-1:0] far_x, far_y, far_z, near_x, near_y, near_z;
  int fail_count, pending;
  int cycle = 0;
  int hits_seen [3];

  ray_sphere_intersect DUT (.*);
  rsi_checker u_checker (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [CB-1:0] rand_coord(input int mode);
    case (mode)
      0: rand_coord = $urandom;
      1: rand_coord = $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      2: rand_coord = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: rand_coord = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  task automatic send(input logic [CB-1:0] c [3], input logic [CB-2:0] r,
                      input logic [CB-1:0] p [3], input logic [CB-1:0] d [3]);
    start <= 1'b1;
    {center_x, center_y, center_z} <= {c[0], c[1], c[2]};
    sphere_radius <= r;
    {start_x, start_y, start_z} <= {p[0], p[1], p[2]};
    {heading_x, heading_y, heading_z} <= {d[0], d[1], d[2]};
    do @(posedge clk); while (busy);
  endtask

  task automatic send_item(input logic [CB-1:0] c [3], input logic [CB-2:0] r,
                           input logic [CB-1:0] p [3], input logic [CB-1:0] d [3],
                           input bit gaps);
    while (gaps && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    send(c, r, p, d);
  endtask

  initial begin
    logic [CB-1:0] c [3], p [3], d [3];
    logic [CB-2:0] r;
    int mode, wait_n;
    rst = 1'b1;
    start = 1'b0;
    {center_x, center_y, center_z, start_x, start_y, start_z} = '0;
    {heading_x, heading_y, heading_z} = '0;
    sphere_radius = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: crossing, tangent, miss, zero heading, extremes
    c = '{0, 0, 0}; p = '{32'hFFF6_0000, 0, 0}; d = '{32'h0001_0000, 0, 0};
    send_item(c, 31'h0002_0000, p, d, 0);
    p = '{32'hFFF6_0000, 32'h0002_0000, 0};
    send_item(c, 31'h0002_0000, p, d, 0);
    p = '{32'hFFF6_0000, 32'h0005_0000, 0};
    send_item(c, 31'h0002_0000, p, d, 0);
    d = '{0, 0, 0}; p = '{32'h0001_0000, 0, 0};
    send_item(c, 31'h0002_0000, p, d, 0);
    send_item(c, 31'h0001_0000, p, d, 0);
    send_item(c, 31'h0000_8000, p, d, 0);
    p = '{0, 0, 0};
    send_item(c, 31'h0, p, d, 0);
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    d = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_item(c, 31'h7FFF_FFFF, p, d, 0);
    d = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_item(c, 31'h7FFF_FFFF, p, d, 0);
    c = '{32'h7FFF_FFFF, 0, 0}; p = '{32'h8000_0000, 0, 0};
    d = '{32'h0000_0001, 0, 0};
    send_item(c, 31'h7FFF_FFFF, p, d, 0);
    c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; p = '{1, 1, 1};
    d = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_item(c, 31'h5555_5555, p, d, 0);
    start <= 1'b0;

    // hold until the pipeline drains
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < 500; n++) begin
      mode = $urandom_range(0, 9) < 7 ? 3 : $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        c[i] = rand_coord(mode);
        p[i] = c[i] + rand_coord(mode == 0 ? 0 : 1);
        d[i] = $urandom_range(0, 19) == 0 ? '0 : rand_coord($urandom_range(0, 3));
      end
      r = mode == 0 || mode == 2 ? 31'($urandom) : 31'($urandom_range(0, 32'h0008_0000));
      send_item(c, r, p, d, n < 150 || n >= 250);
    end
    start <= 1'b0;

    wait_n = 0;
    while (pending != 0 && wait_n < 4 * LATENCY) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("Ran %0d queries: %0d misses, %0d tangents, %0d crossings.",
             hits_seen[0] + hits_seen[1] + hits_seen[2],
             hits_seen[0], hits_seen[1], hits_seen[2]);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: ray_sphere_intersect.f
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_isqrt.sv
hw/rtl/ray_sphere_intersect.sv
dv/rsi_checker.sv
dv/tb.sv
